// ===== sv/wfd_pkg.sv =====
// wfd_pkg: shared types and constants for the wall-follow drive controller
// used by wfd_step, wall_follow_drive_fsm and wfd_checker; no dependencies
`timescale 1ns / 1ps

package wfd_pkg;

    // drive modes, also the encoding of the mode_code result field
    typedef enum logic [2:0] {
        MODE_WAIT_WALL   = 3'd0,
        MODE_WAIT_CLEAR  = 3'd1,
        MODE_FOLLOW      = 3'd2,
        MODE_TURN_LEFT   = 3'd3,
        MODE_TURN_RIGHT  = 3'd4,
        MODE_NUDGE_LEFT  = 3'd5,
        MODE_NUDGE_RIGHT = 3'd6,
        MODE_RESUME      = 3'd7
    } mode_t;

    // motor direction codes
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SAFE_DIST       = 3'd0,
        REG_FRONT_SAFE_DIST = 3'd1,
        REG_WALL_MARGIN     = 3'd2,
        REG_NUDGE_ANGLE     = 3'd3,
        REG_TURN_MARGIN     = 3'd4,
        REG_DRIVE_SPEED     = 3'd5
    } reg_idx_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int DIST_W      = 10;
    localparam int YAW_W       = 16;
    localparam int HEAD_W      = 18;
    localparam int ANGLE_W     = 12;
    localparam int SPEED_W     = 8;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 32;

    // 90 degrees in tenths
    localparam logic signed [HEAD_W-1:0] TURN_TENTHS = 18'sd900;

    localparam logic [DIST_W-1:0]  SAFE_DIST_RST       = 10'd30;
    localparam logic [DIST_W-1:0]  FRONT_SAFE_DIST_RST = 10'd30;
    localparam logic [DIST_W-1:0]  WALL_MARGIN_RST     = 10'd5;
    localparam logic [ANGLE_W-1:0] NUDGE_ANGLE_RST     = 12'd100;
    localparam logic [DIST_W-1:0]  TURN_MARGIN_RST     = 10'd100;
    localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST     = 8'd255;

    typedef struct packed {
        logic [DIST_W-1:0]  safe_dist;
        logic [DIST_W-1:0]  front_safe_dist;
        logic [DIST_W-1:0]  wall_margin;
        logic [ANGLE_W-1:0] nudge_angle;
        logic [DIST_W-1:0]  turn_margin;
        logic [SPEED_W-1:0] drive_speed;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0]        front_dist;
        logic [DIST_W-1:0]        back_dist;
        logic [DIST_W-1:0]        right_dist;
        logic signed [YAW_W-1:0]  yaw;
    } item_t;

    typedef struct packed {
        mode_t                    current;
        mode_t                    pending;
        logic                     first;
        logic signed [HEAD_W-1:0] target;
    } ctrl_state_t;

    typedef struct packed {
        logic               drive_update;
        dir_t               left_dir;
        logic [SPEED_W-1:0] left_speed;
        dir_t               right_dir;
        logic [SPEED_W-1:0] right_speed;
        mode_t              mode;
        logic               front_blocked;
        logic               back_blocked;
        logic               right_blocked;
    } result_t;

endpackage

// ===== sv/wfd_step.sv =====
// wfd_step: one controller tick, flags, mode transition and motor command
// combinational; depends on wfd_pkg
`timescale 1ns / 1ps

module wfd_step (
    input  wfd_pkg::cfg_t        cfg,
    input  wfd_pkg::ctrl_state_t state_cur,
    input  wfd_pkg::item_t       item,
    output wfd_pkg::ctrl_state_t state_next,
    output wfd_pkg::result_t     result
);
    import wfd_pkg::*;

    logic                     front_blk;
    logic                     back_blk;
    logic                     right_blk;
    logic signed [11:0]       band_lo;
    logic [10:0]              band_hi;
    logic                     too_close;
    logic                     too_far;
    logic signed [HEAD_W-1:0] yaw_ext;
    logic signed [HEAD_W-1:0] turn_m;
    logic signed [HEAD_W-1:0] nudge_a;
    mode_t                    pend;
    logic signed [HEAD_W-1:0] tgt;
    mode_t                    cur;
    dir_t                     ldir;
    dir_t                     rdir;
    logic                     upd;

    assign front_blk = item.front_dist <= cfg.front_safe_dist;
    assign back_blk  = item.back_dist  <= cfg.safe_dist;
    assign right_blk = item.right_dist <= cfg.safe_dist;

    // lower band edge can go negative
    assign band_lo   = signed'({2'b00, cfg.safe_dist}) - signed'({2'b00, cfg.wall_margin});
    assign band_hi   = {1'b0, cfg.safe_dist} + {1'b0, cfg.wall_margin};
    assign too_close = signed'({2'b00, item.right_dist}) < band_lo;
    assign too_far   = {1'b0, item.right_dist} > band_hi;

    assign yaw_ext = HEAD_W'(item.yaw);
    assign turn_m  = signed'({8'd0, cfg.turn_margin});
    assign nudge_a = signed'({6'd0, cfg.nudge_angle});

    always_comb begin
        pend = state_cur.pending;
        tgt  = state_cur.target;
        case (state_cur.current)
            MODE_WAIT_WALL: begin
                if (right_blk && back_blk) pend = MODE_WAIT_CLEAR;
            end
            MODE_WAIT_CLEAR: begin
                if (!front_blk) pend = MODE_FOLLOW;
            end
            MODE_FOLLOW: begin
                if (front_blk) begin
                    pend = MODE_TURN_LEFT;
                    tgt  = yaw_ext + TURN_TENTHS - turn_m;
                end else if (!right_blk) begin
                    pend = MODE_TURN_RIGHT;
                    tgt  = yaw_ext - TURN_TENTHS + turn_m;
                end else if (too_close) begin
                    pend = MODE_NUDGE_LEFT;
                    tgt  = yaw_ext + nudge_a;
                end else if (too_far) begin
                    pend = MODE_NUDGE_RIGHT;
                    tgt  = yaw_ext - nudge_a;
                end
            end
            MODE_TURN_LEFT: begin
                if (state_cur.target <= yaw_ext) pend = MODE_RESUME;
            end
            MODE_TURN_RIGHT: begin
                if (state_cur.target >= yaw_ext) pend = MODE_RESUME;
            end
            MODE_NUDGE_LEFT: begin
                if (state_cur.target <= yaw_ext) pend = MODE_FOLLOW;
            end
            MODE_NUDGE_RIGHT: begin
                if (state_cur.target >= yaw_ext) pend = MODE_FOLLOW;
            end
            MODE_RESUME: begin
                if (right_blk) pend = MODE_FOLLOW;
            end
            default: begin
                pend = state_cur.pending;
            end
        endcase
    end

    // first tick after reset forces the start mode, pending keeps its value
    assign cur = state_cur.first ? MODE_WAIT_WALL : pend;

    always_comb begin
        ldir = DIR_STOP;
        rdir = DIR_STOP;
        upd  = 1'b1;
        case (cur)
            MODE_FOLLOW, MODE_RESUME: begin
                ldir = DIR_FWD;
                rdir = DIR_BACK;
            end
            MODE_TURN_LEFT: begin
                ldir = DIR_BACK;
                rdir = DIR_BACK;
            end
            MODE_TURN_RIGHT: begin
                ldir = DIR_FWD;
                rdir = DIR_FWD;
            end
            MODE_NUDGE_LEFT: begin
                rdir = DIR_BACK;
            end
            MODE_NUDGE_RIGHT: begin
                ldir = DIR_FWD;
            end
            default: begin
                upd = 1'b0;
            end
        endcase
    end

    assign state_next.current = cur;
    assign state_next.pending = pend;
    assign state_next.first   = 1'b0;
    assign state_next.target  = tgt;

    assign result.drive_update  = upd;
    assign result.left_dir      = ldir;
    assign result.left_speed    = (ldir != DIR_STOP) ? cfg.drive_speed : '0;
    assign result.right_dir     = rdir;
    assign result.right_speed   = (rdir != DIR_STOP) ? cfg.drive_speed : '0;
    assign result.mode          = cur;
    assign result.front_blocked = front_blk;
    assign result.back_blocked  = back_blk;
    assign result.right_blocked = right_blk;

endmodule

// ===== sv/wall_follow_drive_fsm.sv =====
// wall_follow_drive_fsm: top level of the right-wall-following drive controller
// input register, wfd_step logic, result register; depends on wfd_pkg, wfd_step
`timescale 1ns / 1ps

// Usage
//   s_ channel: one sensor tick per beat (front, back, right distance, yaw).
//   m_ channel: one result beat per tick: motor command, mode, obstacle flags.
//   cfg port: cfg_wr_en writes cfg_wdata into register cfg_index at the clock
//   edge; write only while no tick is in flight. Unknown indexes are ignored.
// Path: an accepted tick is held in the input register, then stepped into the
//   result register, from which the result beat is offered on m_.
// Throughput: one tick per cycle while m_tready stays high, set by the state
//   update loop (mode, pending mode and target heading are written with the result).
// Reset (aresetn low, synchronous): both stages empty, registers at their
//   defaults, mode wait-for-wall, first-tick flag set so the first tick after
//   reset reports wait-for-wall.
// Stall: while m_tready is low the result beat holds; one more tick is taken
//   into the input register, then s_tready drops until the result is taken.
module wall_follow_drive_fsm (
    input  logic                                aclk,
    input  logic                                aresetn,
    // fields from bit 0: front_distance[9:0], back_distance[19:10],
    // right_distance[29:20], yaw_angle[45:30], zero fill [47:46]
    input  logic [wfd_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields from bit 0: drive_update[0], left_direction[2:1],
    // left_speed[10:3], right_direction[12:11], right_speed[20:13],
    // mode_code[23:21], front_blocked[24], back_blocked[25],
    // right_blocked[26], zero fill [31:27]
    output logic [wfd_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wr_en,
    input  logic [wfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import wfd_pkg::*;

    cfg_t        cfg_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    item_t       in_item_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    result_t     result_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic        advance;
    logic        s_accept;

    // input stage moves to the result register when that is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    wfd_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign out_data_next = {
        5'd0,
        result_next.right_blocked,
        result_next.back_blocked,
        result_next.front_blocked,
        result_next.mode,
        result_next.right_speed,
        result_next.right_dir,
        result_next.left_speed,
        result_next.left_dir,
        result_next.drive_update
    };

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.safe_dist       <= SAFE_DIST_RST;
            cfg_reg.front_safe_dist <= FRONT_SAFE_DIST_RST;
            cfg_reg.wall_margin     <= WALL_MARGIN_RST;
            cfg_reg.nudge_angle     <= NUDGE_ANGLE_RST;
            cfg_reg.turn_margin     <= TURN_MARGIN_RST;
            cfg_reg.drive_speed     <= DRIVE_SPEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SAFE_DIST:       cfg_reg.safe_dist       <= cfg_wdata[DIST_W-1:0];
                REG_FRONT_SAFE_DIST: cfg_reg.front_safe_dist <= cfg_wdata[DIST_W-1:0];
                REG_WALL_MARGIN:     cfg_reg.wall_margin     <= cfg_wdata[DIST_W-1:0];
                REG_NUDGE_ANGLE:     cfg_reg.nudge_angle     <= cfg_wdata[ANGLE_W-1:0];
                REG_TURN_MARGIN:     cfg_reg.turn_margin     <= cfg_wdata[DIST_W-1:0];
                REG_DRIVE_SPEED:     cfg_reg.drive_speed     <= cfg_wdata[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // controller state, stepped once per tick that reaches the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.current <= MODE_WAIT_WALL;
            state_reg.pending <= MODE_WAIT_WALL;
            state_reg.first   <= 1'b1;
            state_reg.target  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // valid flags of both stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.front_dist <= s_tdata[9:0];
            in_item_reg.back_dist  <= s_tdata[19:10];
            in_item_reg.right_dist <= s_tdata[29:20];
            in_item_reg.yaw        <= signed'(s_tdata[45:30]);
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== sv/wfd_checker.sv =====
// wfd_checker: port-level assertions for wall_follow_drive_fsm, bound to the top
// depends on wfd_pkg and wall_follow_drive_fsm
`timescale 1ns / 1ps

module wfd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [wfd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import wfd_pkg::*;

    logic [2:0] mode_f;
    logic [1:0] ldir_f;
    logic [1:0] rdir_f;

    assign mode_f = m_tdata[23:21];
    assign ldir_f = m_tdata[2:1];
    assign rdir_f = m_tdata[12:11];

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // wait modes never drive the motors
    a_wait_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (mode_f == MODE_WAIT_WALL || mode_f == MODE_WAIT_CLEAR)
        |-> m_tdata[0] == 1'b0 && ldir_f == DIR_STOP && rdir_f == DIR_STOP)
        else $error("motor command in a wait mode");

    // stopped motors report zero speed
    a_stop_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (ldir_f == DIR_STOP || rdir_f == DIR_STOP)
        |-> (ldir_f != DIR_STOP || m_tdata[10:3] == 8'd0)
            && (rdir_f != DIR_STOP || m_tdata[20:13] == 8'd0))
        else $error("nonzero speed on a stopped motor");

    // follow mode drives left forward, right backward
    a_follow_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_f == MODE_FOLLOW
        |-> m_tdata[0] && ldir_f == DIR_FWD && rdir_f == DIR_BACK)
        else $error("wrong motor pattern in follow mode");

    // a tick taken behind a stalled result fills the pipe, input then follows output
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && s_tvalid && s_tready
        |=> m_tvalid && (s_tready == m_tready))
        else $error("backpressure check failed");

endmodule

bind wall_follow_drive_fsm wfd_checker u_wfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== tb/wall_follow_drive_fsm_tb.sv =====
// wall_follow_drive_fsm_tb: self-checking bench for the wall-follow drive controller
// directed sensor ticks, then randomized phases under varied register settings;
// depends on wfd_pkg and wall_follow_drive_fsm
`timescale 1ns / 1ps

module wall_follow_drive_fsm_tb;
    import wfd_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int TICKS_PER_PHASE = 90;
    localparam int NO_IDLE_PHASE   = 4;   // both sides run flat out here
    localparam int PRESSURE_PHASE  = 3;   // sender drains the pipe halfway through
    localparam int IDLE_PCT        = 34;
    localparam int SETTLE_CYCLES   = 4;
    localparam int STALL_LIMIT     = 2000;
    localparam int REPORT_CAP      = 40;

    // indexes past the last register, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_IDX_SPARE_HI = 3'd7;

    // raw write data for one register setting, 12 bits so over-range bits get exercised
    typedef struct packed {
        logic [CFG_DATA_W-1:0] safe;
        logic [CFG_DATA_W-1:0] front;
        logic [CFG_DATA_W-1:0] margin;
        logic [CFG_DATA_W-1:0] nudge;
        logic [CFG_DATA_W-1:0] turn;
        logic [CFG_DATA_W-1:0] speed;
    } drive_setting_t;

    // one row of the directed sequence; want only used where typed
    typedef struct {
        item_t   tick;
        bit      typed;
        result_t want;
    } tick_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // predictor copy of the controller state and registers
    cfg_t                     cmd_cfg;
    mode_t                    cmd_mode;
    mode_t                    cmd_pending;
    bit                       cmd_first;
    logic signed [HEAD_W-1:0] cmd_target;

    result_t        expected_cmds[$];
    tick_row_t      directed_rows[$];
    drive_setting_t settings[NUM_PHASES];

    bit       no_idle = 1'b0;
    int       heading_walk;
    int       mismatch_count = 0;
    int       beats_checked = 0;
    int       ticks_sent = 0;
    int       reg_writes = 0;
    int       idle_cycles = 0;
    bit [7:0] modes_seen = '0;
    result_t  checker_want;

    wall_follow_drive_fsm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one mismatch line per failure, capped so a broken block cannot flood the log
    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("[%0t] result beat %0d: %s got %0d want %0d",
                     $time, beats_checked, field, got, want);
    endtask

    // steps the predicted controller by one sensor tick and returns its command
    function automatic result_t predict_drive_cmd(input item_t tick);
        result_t cmd;
        int      yaw_i;
        int      tgt_i;
        int      lo_edge;
        int      hi_edge;
        bit      front_b;
        bit      back_b;
        bit      right_b;
        yaw_i   = int'($signed(tick.yaw));
        tgt_i   = int'(cmd_target);
        front_b = tick.front_dist <= cmd_cfg.front_safe_dist;
        back_b  = tick.back_dist <= cmd_cfg.safe_dist;
        right_b = tick.right_dist <= cmd_cfg.safe_dist;
        // the lower band edge can go below zero when the margin exceeds the target distance
        lo_edge = int'(cmd_cfg.safe_dist) - int'(cmd_cfg.wall_margin);
        hi_edge = int'(cmd_cfg.safe_dist) + int'(cmd_cfg.wall_margin);

        // next mode goes to the pending register, which holds when nothing fires
        case (cmd_mode)
            MODE_WAIT_WALL: if (right_b && back_b) cmd_pending = MODE_WAIT_CLEAR;
            MODE_WAIT_CLEAR: if (!front_b) cmd_pending = MODE_FOLLOW;
            MODE_FOLLOW: begin
                if (front_b) begin
                    cmd_pending = MODE_TURN_LEFT;
                    cmd_target  = HEAD_W'(yaw_i + int'(TURN_TENTHS)
                                          - int'(cmd_cfg.turn_margin));
                end else if (!right_b) begin
                    cmd_pending = MODE_TURN_RIGHT;
                    cmd_target  = HEAD_W'(yaw_i - int'(TURN_TENTHS)
                                          + int'(cmd_cfg.turn_margin));
                end else if (int'(tick.right_dist) < lo_edge) begin
                    cmd_pending = MODE_NUDGE_LEFT;
                    cmd_target  = HEAD_W'(yaw_i + int'(cmd_cfg.nudge_angle));
                end else if (int'(tick.right_dist) > hi_edge) begin
                    cmd_pending = MODE_NUDGE_RIGHT;
                    cmd_target  = HEAD_W'(yaw_i - int'(cmd_cfg.nudge_angle));
                end
            end
            MODE_TURN_LEFT:   if (tgt_i <= yaw_i) cmd_pending = MODE_RESUME;
            MODE_TURN_RIGHT:  if (tgt_i >= yaw_i) cmd_pending = MODE_RESUME;
            MODE_NUDGE_LEFT:  if (tgt_i <= yaw_i) cmd_pending = MODE_FOLLOW;
            MODE_NUDGE_RIGHT: if (tgt_i >= yaw_i) cmd_pending = MODE_FOLLOW;
            default:          if (right_b) cmd_pending = MODE_FOLLOW;
        endcase

        // first tick after reset reports wait-for-wall but keeps the pending mode
        if (cmd_first) begin
            cmd_mode  = MODE_WAIT_WALL;
            cmd_first = 1'b0;
        end else begin
            cmd_mode = cmd_pending;
        end

        cmd = '0;
        cmd.mode          = cmd_mode;
        cmd.drive_update  = 1'b1;
        cmd.left_dir      = DIR_STOP;
        cmd.right_dir     = DIR_STOP;
        cmd.front_blocked = front_b;
        cmd.back_blocked  = back_b;
        cmd.right_blocked = right_b;
        case (cmd_mode)
            MODE_FOLLOW, MODE_RESUME: begin
                cmd.left_dir  = DIR_FWD;
                cmd.right_dir = DIR_BACK;
            end
            MODE_TURN_LEFT: begin
                cmd.left_dir  = DIR_BACK;
                cmd.right_dir = DIR_BACK;
            end
            MODE_TURN_RIGHT: begin
                cmd.left_dir  = DIR_FWD;
                cmd.right_dir = DIR_FWD;
            end
            MODE_NUDGE_LEFT:  cmd.right_dir = DIR_BACK;
            MODE_NUDGE_RIGHT: cmd.left_dir  = DIR_FWD;
            default:          cmd.drive_update = 1'b0;   // wait states hold the motors
        endcase
        cmd.left_speed  = (cmd.left_dir != DIR_STOP) ? cmd_cfg.drive_speed : '0;
        cmd.right_speed = (cmd.right_dir != DIR_STOP) ? cmd_cfg.drive_speed : '0;
        return cmd;
    endfunction

    task automatic add_row(input int fd, input int bd, input int rd, input int yaw,
                           input bit typed = 1'b0, input result_t want = '0);
        tick_row_t row;
        row.tick.front_dist = fd[DIST_W-1:0];
        row.tick.back_dist  = bd[DIST_W-1:0];
        row.tick.right_dist = rd[DIST_W-1:0];
        row.tick.yaw        = yaw[YAW_W-1:0];
        row.typed           = typed;
        row.want            = want;
        directed_rows.push_back(row);
    endtask

    // distance scattered around a threshold, clipped to the sensor range
    function automatic logic [DIST_W-1:0] near_threshold(input int thr, input int spread);
        int v;
        v = thr + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[DIST_W-1:0];
    endfunction

    // offers one tick, with random idle cycles ahead of it, and predicts it on accept
    task automatic send_tick(input item_t tick, input bit typed, input result_t want);
        result_t cmd;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tdata  <= {2'b00, tick.yaw, tick.right_dist, tick.back_dist, tick.front_dist};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        cmd = predict_drive_cmd(tick);
        modes_seen[cmd.mode] = 1'b1;
        expected_cmds.push_back(typed ? want : cmd);
        ticks_sent++;
    endtask

    // stops the sender and waits until every predicted command has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write beat; predictor copy updated at the write edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_SAFE_DIST:       cmd_cfg.safe_dist       = value[DIST_W-1:0];
            REG_FRONT_SAFE_DIST: cmd_cfg.front_safe_dist = value[DIST_W-1:0];
            REG_WALL_MARGIN:     cmd_cfg.wall_margin     = value[DIST_W-1:0];
            REG_NUDGE_ANGLE:     cmd_cfg.nudge_angle     = value[ANGLE_W-1:0];
            REG_TURN_MARGIN:     cmd_cfg.turn_margin     = value[DIST_W-1:0];
            REG_DRIVE_SPEED:     cmd_cfg.drive_speed     = value[SPEED_W-1:0];
            default: ;   // unknown index, no register changes
        endcase
        reg_writes++;
    endtask

    // result side stalls at random except in the no-idle phase
    always @(posedge aclk) begin
        if (no_idle)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // compare every result beat with the oldest prediction, field by field
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch("beat with nothing expected, tdata", int'(m_tdata), 0);
            end else begin
                checker_want = expected_cmds.pop_front();
                if (m_tdata[0] !== checker_want.drive_update)
                    report_mismatch("drive_update", int'(m_tdata[0]),
                                    int'(checker_want.drive_update));
                if (m_tdata[2:1] !== checker_want.left_dir)
                    report_mismatch("left_direction", int'(m_tdata[2:1]),
                                    int'(checker_want.left_dir));
                if (m_tdata[10:3] !== checker_want.left_speed)
                    report_mismatch("left_speed", int'(m_tdata[10:3]),
                                    int'(checker_want.left_speed));
                if (m_tdata[12:11] !== checker_want.right_dir)
                    report_mismatch("right_direction", int'(m_tdata[12:11]),
                                    int'(checker_want.right_dir));
                if (m_tdata[20:13] !== checker_want.right_speed)
                    report_mismatch("right_speed", int'(m_tdata[20:13]),
                                    int'(checker_want.right_speed));
                if (m_tdata[23:21] !== checker_want.mode)
                    report_mismatch("mode_code", int'(m_tdata[23:21]),
                                    int'(checker_want.mode));
                if (m_tdata[24] !== checker_want.front_blocked)
                    report_mismatch("front_blocked", int'(m_tdata[24]),
                                    int'(checker_want.front_blocked));
                if (m_tdata[25] !== checker_want.back_blocked)
                    report_mismatch("back_blocked", int'(m_tdata[25]),
                                    int'(checker_want.back_blocked));
                if (m_tdata[26] !== checker_want.right_blocked)
                    report_mismatch("right_blocked", int'(m_tdata[26]),
                                    int'(checker_want.right_blocked));
            end
            beats_checked++;
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d predictions outstanding",
                     STALL_LIMIT, expected_cmds.size());
            $display("** wall_follow_drive_fsm: FAILED **");
            $finish;
        end
    end

    initial begin
        item_t       tick;
        int          ph;
        int          n;
        int          spread;
        logic [95:0] raw_bits;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;

        // predictor at its reset values
        cmd_cfg.safe_dist       = SAFE_DIST_RST;
        cmd_cfg.front_safe_dist = FRONT_SAFE_DIST_RST;
        cmd_cfg.wall_margin     = WALL_MARGIN_RST;
        cmd_cfg.nudge_angle     = NUDGE_ANGLE_RST;
        cmd_cfg.turn_margin     = TURN_MARGIN_RST;
        cmd_cfg.drive_speed     = DRIVE_SPEED_RST;
        cmd_mode    = MODE_WAIT_WALL;
        cmd_pending = MODE_WAIT_WALL;
        cmd_first   = 1'b1;
        cmd_target  = '0;
        heading_walk = 0;

        // directed ticks under reset settings: threshold 30, band 25..35
        // first tick: all blocked, still reports wait-for-wall
        add_row(0, 0, 0, 0, 1'b1,
                '{1'b0, DIR_STOP, 8'd0, DIR_STOP, 8'd0, MODE_WAIT_WALL, 1'b1, 1'b1, 1'b1});
        // nothing blocked, yet the pending mode from the first tick takes over
        add_row(1023, 1023, 1023, 32767, 1'b1,
                '{1'b0, DIR_STOP, 8'd0, DIR_STOP, 8'd0, MODE_WAIT_CLEAR, 1'b0, 1'b0, 1'b0});
        add_row(30, 1023, 1023, 0);         // front exactly at threshold, keep waiting
        add_row(31, 500, 30, 0);            // front clear, start following
        add_row(500, 31, 25, -100);         // right on the lower band edge, no nudge
        add_row(500, 30, 24, -100);         // below band, nudge left to heading 0
        add_row(500, 30, 24, -1);           // heading short of target
        add_row(500, 30, 24, 0);            // target reached, back to follow
        add_row(30, 500, 30, -32768);       // front blocked at most negative yaw
        add_row(1023, 1023, 1023, -31969);  // one tenth short
        add_row(1023, 1023, 1023, -31968);  // turn done, resume
        add_row(1023, 1023, 31, 0);         // no wall on the right yet
        add_row(1023, 1023, 0, 0);          // wall found, follow
        add_row(31, 0, 31, 32767);          // wall lost, right turn from top yaw
        add_row(0, 0, 0, 31968);            // still above target
        add_row(0, 0, 0, 31967);            // target reached
        add_row(0, 0, 0, 100);
        add_row(1023, 0, 0, 5);             // too close to the wall, nudge left
        add_row(1023, 0, 0, 32767);         // overshoot ends the nudge
        add_row(0, 1023, 1023, -32768);     // front block wins over lost wall
        add_row(0, 0, 0, -31968);
        add_row(0, 0, 30, 0);

        // register settings per phase: extremes first, then mixed and random
        settings[0] = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
        settings[1] = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
        // margin above the wall target: lower band edge negative
        settings[2] = '{12'd12, 12'd25, 12'd40, 12'd300, 12'd0, 12'd128};
        settings[3] = '{12'd30, 12'd30, 12'd5, 12'd100, 12'd100, 12'd255};
        settings[4] = '{12'd200, 12'd150, 12'd20, 12'd3600, 12'd900, 12'd1};
        for (ph = 5; ph < NUM_PHASES; ph++) begin
            settings[ph].safe   = CFG_DATA_W'($urandom_range(0, 1023));
            settings[ph].front  = CFG_DATA_W'($urandom_range(0, 1023));
            settings[ph].margin = CFG_DATA_W'($urandom_range(0, 60));
            settings[ph].nudge  = CFG_DATA_W'($urandom_range(0, 3600));
            settings[ph].turn   = CFG_DATA_W'($urandom_range(0, 900));
            settings[ph].speed  = CFG_DATA_W'($urandom_range(0, 255));
        end
        // one random phase with full-width write data, upper bits dropped by the block
        raw_bits    = {$urandom, $urandom, $urandom};
        settings[6] = raw_bits[71:0];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            // registers change only with the pipe empty
            drain_results();
            write_reg(REG_SAFE_DIST, settings[ph].safe);
            write_reg(REG_FRONT_SAFE_DIST, settings[ph].front);
            write_reg(REG_WALL_MARGIN, settings[ph].margin);
            write_reg(REG_NUDGE_ANGLE, settings[ph].nudge);
            write_reg(REG_TURN_MARGIN, settings[ph].turn);
            write_reg(REG_DRIVE_SPEED, settings[ph].speed);
            write_reg(ph[0] ? REG_IDX_SPARE_HI : REG_IDX_SPARE_LO,
                      CFG_DATA_W'($urandom_range(0, 4095)));
            cfg_wr_en <= 1'b0;
            no_idle = (ph == NO_IDLE_PHASE);

            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                if (ph == PRESSURE_PHASE && n == TICKS_PER_PHASE / 2)
                    drain_results();

                // yaw drifts so turns and nudges finish, with rare jumps anywhere
                if ($urandom_range(0, 99) < 8)
                    heading_walk = int'($urandom_range(0, 65535)) - 32768;
                else
                    heading_walk += int'($urandom_range(0, 800)) - 400;
                if (heading_walk > 32767) heading_walk = 32767;
                if (heading_walk < -32768) heading_walk = -32768;
                tick.yaw = heading_walk[YAW_W-1:0];

                // mostly near the thresholds so the machine keeps following the wall
                if ($urandom_range(0, 99) < 25)
                    tick.front_dist = near_threshold(int'(cmd_cfg.front_safe_dist), 4);
                else
                    tick.front_dist = DIST_W'($urandom_range(0, 1023));
                if ($urandom_range(0, 99) < 50)
                    tick.back_dist = near_threshold(int'(cmd_cfg.safe_dist), 4);
                else
                    tick.back_dist = DIST_W'($urandom_range(0, 1023));
                spread = (cmd_cfg.wall_margin > 40) ? 44 : int'(cmd_cfg.wall_margin) + 4;
                if ($urandom_range(0, 99) < 85)
                    tick.right_dist = near_threshold(int'(cmd_cfg.safe_dist), spread);
                else
                    tick.right_dist = DIST_W'($urandom_range(0, 1023));

                send_tick(tick, 1'b0, '0);
            end
        end
        no_idle = 1'b0;
        drain_results();

        $display("covered %0d sensor ticks and %0d result beats over %0d register settings",
                 ticks_sent, beats_checked, NUM_PHASES + 1);
        $display("%0d register writes, modes reached (bit per mode code): %b",
                 reg_writes, modes_seen);
        if (mismatch_count == 0) begin
            $display("** wall_follow_drive_fsm: PASSED **");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("** wall_follow_drive_fsm: FAILED **");
        end
        $finish;
    end

endmodule
